@@ rtl/core/gmb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the gray histogram mode binarizer.
package gmb_pkg;

   localparam int unsigned GRAY_W       = 8;
   localparam int unsigned MODE_LEVEL_W = 8;
   localparam int unsigned COUNT_W      = 20;
   localparam int unsigned THRESH_W     = 9;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd128;

   // Bins stop counting at the lesser of the pixel budget and the field maximum.
   localparam int unsigned MAX_PIXELS    = 524288;
   localparam int unsigned COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
   localparam logic [COUNT_W-1:0] COUNT_CAP =
      COUNT_W'((MAX_PIXELS < COUNT_FIELD_MAX) ? MAX_PIXELS : COUNT_FIELD_MAX);

   typedef struct packed {
      logic                    binary_pixel;
      logic                    frame_done;
      logic [MODE_LEVEL_W-1:0] mode_level;
      logic [COUNT_W-1:0]      mode_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } buf_status_type;

endpackage

@@ rtl/core/gmb_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module gmb_ram #(
   parameter int unsigned WIDTH = 20,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/gmb_out_buf.sv @@
`timescale 1ns / 1ps
// Two-entry result buffer between the histogram pipeline and the rsp_ channel.
module gmb_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  gmb_pkg::rsp_type        push_data,
   output gmb_pkg::buf_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output gmb_pkg::rsp_type        rsp_data
);

   gmb_pkg::rsp_type entry_ff [2];
   logic       head_ff;
   logic       head_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;
   logic       wr_ptr;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid & rsp_ready;
   assign wr_ptr    = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = head_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr] <= push_data;
      end
   end

   assign status.count = count_ff;
   assign status.pop   = pop;

endmodule

@@ rtl/core/gmb_hist.sv @@
`timescale 1ns / 1ps
// Histogram read-modify-write pipeline, running mode tracker and clearing sweep.
module gmb_hist #(
   parameter int unsigned NUM_LEVELS = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gmb_pkg::GRAY_W-1:0]      req_gray_level,
   input  logic                            req_last_pixel,
   input  logic [gmb_pkg::THRESH_W-1:0]    threshold,
   input  gmb_pkg::buf_status_type         buf_status,
   output logic                            res_push,
   output gmb_pkg::rsp_type                res_data
);

   localparam int unsigned LEVEL_W = $clog2(NUM_LEVELS);
   localparam int unsigned COUNT_W = gmb_pkg::COUNT_W;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_CLEAR = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [LEVEL_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic [LEVEL_W-1:0]   s1_bin_ff;
   logic                 s1_last_ff;
   logic                 s1_bpix_ff;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [LEVEL_W-1:0]   fwd_addr_ff;
   logic [COUNT_W-1:0]   fwd_data_ff;
   logic [LEVEL_W-1:0]   best_lvl_ff, best_lvl_in;
   logic [COUNT_W-1:0]   best_cnt_ff, best_cnt_in;

   logic                 accept;
   logic [LEVEL_W-1:0]   req_bin;
   logic                 req_bpix;
   logic [1:0]           pending;
   logic [COUNT_W-1:0]   rd_data;
   logic [COUNT_W-1:0]   cur_cnt;
   logic [COUNT_W-1:0]   new_cnt;
   logic                 better;
   logic [LEVEL_W-1:0]   lvl_next;
   logic [COUNT_W-1:0]   cnt_next;
   logic [31:0]          lvl_wide;
   logic                 wr_en;
   logic [LEVEL_W-1:0]   wr_addr;
   logic [COUNT_W-1:0]   wr_data;

   // Items in flight plus buffered results never exceed the buffer depth.
   assign pending   = {1'b0, s1_valid_ff} + buf_status.count;
   assign req_ready = (state_ff == ST_RUN) && !(s1_valid_ff && s1_last_ff) &&
                      ((pending < 2'd2) || ((pending == 2'd2) && buf_status.pop));
   assign accept    = req_valid & req_ready;

   always_comb begin
      if (32'(req_gray_level) >= NUM_LEVELS) begin
         req_bin = LEVEL_W'(NUM_LEVELS - 1);
      end else begin
         req_bin = LEVEL_W'(req_gray_level);
      end
      req_bpix = ({1'b0, req_gray_level} >= threshold);
   end

   gmb_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_LEVELS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req_bin),
      .rd_data (rd_data)
   );

   // Back-to-back hits on one bin: the RAM still shows the old count.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_bin_ff)) begin
         cur_cnt = fwd_data_ff;
      end else begin
         cur_cnt = rd_data;
      end
      new_cnt = (cur_cnt < gmb_pkg::COUNT_CAP) ? cur_cnt + 1'b1 : cur_cnt;
      better  = (new_cnt > best_cnt_ff) ||
                ((new_cnt == best_cnt_ff) && (s1_bin_ff < best_lvl_ff));
      lvl_next = better ? s1_bin_ff : best_lvl_ff;
      cnt_next = better ? new_cnt : best_cnt_ff;
      lvl_wide = 32'(lvl_next);
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_valid_ff;
         wr_addr = s1_bin_ff;
         wr_data = new_cnt;
      end
   end

   always_comb begin
      res_push              = s1_valid_ff;
      res_data.binary_pixel = s1_bpix_ff;
      res_data.frame_done   = s1_last_ff;
      res_data.mode_level   = s1_last_ff ? lvl_wide[gmb_pkg::MODE_LEVEL_W-1:0] : '0;
      res_data.mode_count   = s1_last_ff ? cnt_next : '0;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      s1_valid_in  = accept;
      fwd_valid_in = s1_valid_ff & ~s1_last_ff;
      best_lvl_in  = best_lvl_ff;
      best_cnt_in  = best_cnt_ff;
      case (state_ff)
         ST_RUN: begin
            if (s1_valid_ff && s1_last_ff) begin
               state_in    = ST_CLEAR;
               clr_addr_in = '0;
               best_lvl_in = '0;
               best_cnt_in = '0;
            end else if (s1_valid_ff) begin
               best_lvl_in = lvl_next;
               best_cnt_in = cnt_next;
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LEVEL_W'(NUM_LEVELS - 1)) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in    = ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         best_lvl_ff  <= '0;
         best_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         best_lvl_ff  <= best_lvl_in;
         best_cnt_ff  <= best_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bin_ff  <= req_bin;
         s1_last_ff <= req_last_pixel;
         s1_bpix_ff <= req_bpix;
      end
      fwd_addr_ff <= s1_bin_ff;
      fwd_data_ff <= new_cnt;
   end

endmodule

@@ rtl/core/gray_histogram_mode_binarizer_top.sv @@
`timescale 1ns / 1ps
// Top level of the gray histogram mode binarizer.
//
// One pixel is taken per clock cycle; its result is registered in the s1 stage
// and then in the result buffer before rsp_valid shows it. Each level's count
// lives in a single histogram RAM that is read when the pixel is accepted and
// written back in the next cycle, with forwarding when the same level arrives
// on consecutive cycles. The mode is tracked as pixels are counted, so the
// result of the frame's last pixel carries it with no extra delay. After that
// last pixel the RAM's one write port sweeps the histogram to zero: req_ready
// stays low while the last pixel drains and then for the sweep, one write per
// level. After reset the same sweep alone holds req_ready low. req_ready also
// drops while the two-entry result buffer is full and the rsp_ side is not
// taking a result. The threshold register on the csr_ port is always ready and
// should only be written while no transaction is in flight.
module gray_histogram_mode_binarizer_top #(
   parameter int unsigned NUM_LEVELS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gmb_pkg::THRESH_W-1:0]        csr_bin_threshold,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gmb_pkg::GRAY_W-1:0]          req_gray_level,
   input  logic                                req_last_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_binary_pixel,
   output logic                                rsp_frame_done,
   output logic [gmb_pkg::MODE_LEVEL_W-1:0]    rsp_mode_level,
   output logic [gmb_pkg::COUNT_W-1:0]         rsp_mode_count
);

   logic [gmb_pkg::THRESH_W-1:0] threshold_ff;
   logic [gmb_pkg::THRESH_W-1:0] threshold_in;
   gmb_pkg::buf_status_type      buf_status;
   logic                         res_push;
   gmb_pkg::rsp_type             res_data;
   gmb_pkg::rsp_type             rsp_data;

   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_bin_threshold : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= gmb_pkg::THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   gmb_hist #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_hist (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_gray_level (req_gray_level),
      .req_last_pixel (req_last_pixel),
      .threshold      (threshold_ff),
      .buf_status     (buf_status),
      .res_push       (res_push),
      .res_data       (res_data)
   );

   gmb_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .status    (buf_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_binary_pixel = rsp_data.binary_pixel;
   assign rsp_frame_done   = rsp_data.frame_done;
   assign rsp_mode_level   = rsp_data.mode_level;
   assign rsp_mode_count   = rsp_data.mode_count;

endmodule

@@ test/tb_gray_histogram_mode_binarizer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the gray histogram mode binarizer top level.
module tb_gray_histogram_mode_binarizer_top;

   localparam int unsigned HIST_LEVELS = 256;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned MAX_PRINTS  = 30;

   typedef struct packed {
      logic [gmb_pkg::GRAY_W-1:0] gray;
      logic                       last;
   } pixel_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [gmb_pkg::THRESH_W-1:0]     csr_bin_threshold = gmb_pkg::THRESH_RESET;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [gmb_pkg::GRAY_W-1:0]       req_gray_level = '0;
   logic                             req_last_pixel = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_binary_pixel;
   logic                             rsp_frame_done;
   logic [gmb_pkg::MODE_LEVEL_W-1:0] rsp_mode_level;
   logic [gmb_pkg::COUNT_W-1:0]      rsp_mode_count;

   pixel_type        pending_pixels[$];
   gmb_pkg::rsp_type expected_results[$];
   gmb_pkg::rsp_type oldest_result;

   // Predictor state
   logic [gmb_pkg::COUNT_W-1:0]  level_counts [HIST_LEVELS];
   logic [gmb_pkg::THRESH_W-1:0] threshold_model = gmb_pkg::THRESH_RESET;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned pixels_sent = 0;
   int unsigned frames_sent = 0;
   int unsigned results_checked = 0;
   int unsigned threshold_writes = 0;

   gray_histogram_mode_binarizer_top #(
      .NUM_LEVELS(HIST_LEVELS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bin_threshold(csr_bin_threshold),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_gray_level   (req_gray_level),
      .req_last_pixel   (req_last_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_binary_pixel (rsp_binary_pixel),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_mode_level   (rsp_mode_level),
      .rsp_mode_count   (rsp_mode_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Counts the pixel, binarizes it and, on the last pixel, finds the mode
   task automatic predict_pixel(input pixel_type px);
      gmb_pkg::rsp_type            r;
      int unsigned                 bin;
      int unsigned                 i;
      logic [7:0]                  top_level;
      logic [gmb_pkg::COUNT_W-1:0] top_count;
      r = '0;
      bin = px.gray;
      if (bin >= HIST_LEVELS)
         bin = HIST_LEVELS - 1;
      if (level_counts[bin] < gmb_pkg::COUNT_CAP)
         level_counts[bin] = level_counts[bin] + 1'b1;
      r.binary_pixel = ({1'b0, px.gray} >= threshold_model);
      if (px.last) begin
         top_level = '0;
         top_count = '0;
         for (i = 0; i < HIST_LEVELS; i++) begin
            // strict compare keeps the lowest level on a tie
            if (level_counts[i] > top_count) begin
               top_count = level_counts[i];
               top_level = i[7:0];
            end
         end
         r.frame_done = 1'b1;
         r.mode_level = top_level;
         r.mode_count = top_count;
         for (i = 0; i < HIST_LEVELS; i++)
            level_counts[i] = '0;
         frames_sent++;
      end
      expected_results.push_back(r);
      pixels_sent++;
   endtask

   // Pixel driver: predicts on acceptance, then offers the next pending pixel
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            predict_pixel('{gray: req_gray_level, last: req_last_pixel});
         if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_gray_level <= pending_pixels[0].gray;
            req_last_pixel <= pending_pixels[0].last;
            void'(pending_pixels.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing outstanding, binary_pixel",
                               rsp_binary_pixel, 0);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_binary_pixel !== oldest_result.binary_pixel)
                  report_mismatch("binary_pixel", rsp_binary_pixel,
                                  oldest_result.binary_pixel);
               if (rsp_frame_done !== oldest_result.frame_done)
                  report_mismatch("frame_done", rsp_frame_done, oldest_result.frame_done);
               if (rsp_mode_level !== oldest_result.mode_level)
                  report_mismatch("mode_level", rsp_mode_level, oldest_result.mode_level);
               if (rsp_mode_count !== oldest_result.mode_count)
                  report_mismatch("mode_count", rsp_mode_count, oldest_result.mode_count);
            end
            results_checked++;
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic push_pixel(input logic [gmb_pkg::GRAY_W-1:0] gray, input logic last);
      pending_pixels.push_back('{gray: gray, last: last});
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [gmb_pkg::THRESH_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_bin_threshold <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      threshold_model = value;
      threshold_writes++;
   endtask

   // Random frames, half of them drawn from a few levels so that modes and ties form
   task automatic queue_random_frames(input int unsigned n_pixels);
      int unsigned                queued;
      int unsigned                len;
      int unsigned                k;
      bit                         use_palette;
      logic [gmb_pkg::GRAY_W-1:0] palette [3];
      logic [gmb_pkg::GRAY_W-1:0] gray;
      queued = 0;
      while (queued < n_pixels) begin
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(24, 2);
         use_palette = ($urandom_range(1) == 1);
         palette[0] = ($urandom_range(3) == 0) ? 8'hFF :
                      gmb_pkg::GRAY_W'($urandom_range(255));
         palette[1] = ($urandom_range(3) == 0) ? 8'h00 :
                      gmb_pkg::GRAY_W'($urandom_range(255));
         palette[2] = gmb_pkg::GRAY_W'($urandom_range(255));
         for (k = 0; k < len; k++) begin
            gray = use_palette ? palette[$urandom_range(2)] :
                   gmb_pkg::GRAY_W'($urandom_range(255));
            push_pixel(gray, k == len - 1);
         end
         queued += len;
      end
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input logic [gmb_pkg::THRESH_W-1:0] thresh,
                            input bit hold_off);
      write_threshold(thresh);
      idle_pct = idle;
      stall_pct = stall;
      queue_random_frames(100);
      if (hold_off)
         hold_requests++;
      wait_drained();
   endtask

   initial begin
      int unsigned i;
      for (i = 0; i < HIST_LEVELS; i++)
         level_counts[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes around the reset threshold
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd127, 1'b0);
      push_pixel(8'd128, 1'b1);
      // tie reached later by the lower level
      push_pixel(8'd200, 1'b0);
      push_pixel(8'd200, 1'b0);
      push_pixel(8'd50, 1'b0);
      push_pixel(8'd50, 1'b1);
      // single-pixel frame
      push_pixel(8'd255, 1'b1);
      // back-to-back repeats of one level
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd3, 1'b0);
      push_pixel(8'd9, 1'b1);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd0, 1'b1);
      wait_drained();

      // Threshold extremes: 0 makes all white, 256 all black
      write_threshold(9'd0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b1);
      wait_drained();
      write_threshold(9'd256);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd0, 1'b1);
      wait_drained();
      write_threshold(9'd255);
      push_pixel(8'd254, 1'b0);
      push_pixel(8'd255, 1'b1);
      wait_drained();
      write_threshold(9'd1);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd1, 1'b1);
      wait_drained();

      // Full rate, with a long receiver hold-off while the sender keeps offering
      run_phase(0, 0, gmb_pkg::THRESH_RESET, 1'b1);

      run_phase(57, 0, 9'($urandom_range(256)), 1'b0);
      run_phase(0, 57, 9'($urandom_range(256)), 1'b0);
      run_phase(27, 27, 9'($urandom_range(256)), 1'b0);
      run_phase(0, 0, 9'($urandom_range(256)), 1'b0);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Run covered %0d pixels in %0d frames, %0d results checked,",
               pixels_sent, frames_sent, results_checked);
      $display("%0d threshold writes, idle and stall mixes with one long hold-off, %0d mismatches.",
               threshold_writes, mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(64'd50_000_000);
      $display("Timeout: transactions still outstanding");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
